// ===== rtl/msu_pkg.sv =====
package msu_pkg;

  localparam int IDX_W   = 12;
  localparam int DATA_W  = 32;
  localparam int COEF_W  = 16;
  localparam int FRAC_W  = 16;
  localparam int PROD_W  = DATA_W + COEF_W + 1;
  localparam int ACC_W   = PROD_W + 1;

  localparam int ELEMENT_DEPTH_DEFAULT = 4096;

  localparam int S_TDATA_W = ((IDX_W + 2 * DATA_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((2 * DATA_W + 7) / 8) * 8;

  localparam int CFG_INDEX_W = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_STEP_RATE       = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_MOMENTUM_FACTOR = CFG_INDEX_W'(1);

  localparam logic [COEF_W-1:0] STEP_RATE_RESET       = COEF_W'(655);
  localparam logic [COEF_W-1:0] MOMENTUM_FACTOR_RESET = COEF_W'(58982);

  localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // result queue depth, power of two
  localparam int FIFO_DEPTH = 8;

  typedef struct packed {
    logic                     saturated;
    logic signed [DATA_W-1:0] velocity;
    logic signed [DATA_W-1:0] weight;
  } result_t;

endpackage

// ===== rtl/msu_index_mod.sv =====
module msu_index_mod #(
  parameter int DEPTH = msu_pkg::ELEMENT_DEPTH_DEFAULT
) (
  input  logic [msu_pkg::IDX_W-1:0] idx_in,
  output logic [msu_pkg::IDX_W-1:0] idx_out
);
  import msu_pkg::*;

  // quotient by reciprocal multiplication, exact for every index of IDX_W bits
  localparam int     RECIP_SHIFT = 2 * IDX_W;
  localparam longint RECIP       = ((longint'(1) << RECIP_SHIFT) + longint'(DEPTH) - 1)
                                   / longint'(DEPTH);
  localparam int     QPROD_W     = IDX_W + RECIP_SHIFT + 1;
  localparam int     DEPTH_W     = $clog2(DEPTH + 1);
  localparam int     BACK_W      = IDX_W + DEPTH_W;

  logic [QPROD_W-1:0] qprod;
  logic [IDX_W-1:0]   quot;
  logic [BACK_W-1:0]  back;

  assign qprod   = QPROD_W'(idx_in) * QPROD_W'(RECIP);
  assign quot    = qprod[RECIP_SHIFT +: IDX_W];
  assign back    = BACK_W'(quot) * BACK_W'(DEPTH);
  assign idx_out = idx_in - back[IDX_W-1:0];

endmodule

// ===== rtl/msu_vel_ram.sv =====
module msu_vel_ram #(
  parameter int DEPTH  = msu_pkg::ELEMENT_DEPTH_DEFAULT,
  parameter int ADDR_W = 12
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [ADDR_W-1:0]                 rd_addr,
  output logic signed [msu_pkg::DATA_W-1:0] rd_data,
  input  logic                              wr_en,
  input  logic [ADDR_W-1:0]                 wr_addr,
  input  logic signed [msu_pkg::DATA_W-1:0] wr_data,
  output logic                              busy
);
  import msu_pkg::*;

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic [ADDR_W-1:0]        clr_addr;

  // zero sweep after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      if (clr_addr == ADDR_W'(DEPTH - 1)) begin
        busy <= 1'b0;
      end else begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/msu_result_fifo.sv =====
module msu_result_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  msu_pkg::result_t push_data,
  output logic             out_valid,
  input  logic             out_ready,
  output msu_pkg::result_t out_data
);
  import msu_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);

  result_t          mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic             pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + (PTR_W + 1)'(push) - (PTR_W + 1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== rtl/momentum_sgd_update_core.sv =====
// Momentum SGD update engine for one weight element per transaction.
// Input stream s_*: element index, current weight and gradient (Q16.16). The
// element's velocity is read from an internal store, updated as
// momentum_factor * v - step_rate * gradient (floored, saturated), written
// back, and added to the weight. Output stream m_*: new weight and velocity,
// with tuser set when either was clipped.
// Configuration port cfg_*: index 0 step rate, index 1 momentum factor,
// both Q0.16; writes are always taken and belong to idle periods.
// Throughput: one item per cycle. An item whose index maps to the same entry
// as the item accepted just before it is held back behind a bubble, as its velocity
// read must follow that item's write-back in the single store.
// Each item passes the stage registers s1 to s5 and then the result queue.
// Reset: rates return to their defaults and the velocity store is cleared
// by a sweep over all ELEMENT_DEPTH entries, during which s_tready stays low.
// A stalled receiver fills an 8-entry result queue; s_tready drops once 8
// items are outstanding and the pipeline stays intact.
module momentum_sgd_update_core #(
  parameter int ELEMENT_DEPTH = msu_pkg::ELEMENT_DEPTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // element_index, weight_value, gradient_value, zero pad
  input  logic [msu_pkg::S_TDATA_W-1:0]    s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // updated_weight, updated_velocity
  output logic [msu_pkg::M_TDATA_W-1:0]    m_tdata,
  // saturated
  output logic                             m_tuser,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [msu_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [msu_pkg::COEF_W-1:0]       cfg_data
);
  import msu_pkg::*;

  localparam int ADDR_W = (ELEMENT_DEPTH > 1) ? $clog2(ELEMENT_DEPTH) : 1;
  localparam int OCC_W  = $clog2(FIFO_DEPTH + 1);

  logic [COEF_W-1:0] step_rate;
  logic [COEF_W-1:0] momentum_factor;

  logic [IDX_W-1:0]         in_index;
  logic signed [DATA_W-1:0] in_weight;
  logic signed [DATA_W-1:0] in_gradient;
  logic [IDX_W-1:0]         idx_rem;

  logic s_fire;
  logic m_fire;
  logic front_stall;
  logic ram_busy;
  logic [OCC_W-1:0] occ;

  logic                     s1_valid;
  logic [IDX_W-1:0]         s1_rem;
  logic signed [DATA_W-1:0] s1_w;
  logic signed [DATA_W-1:0] s1_g;

  logic                     s2_valid;
  logic [ADDR_W-1:0]        s2_addr;
  logic signed [DATA_W-1:0] s2_w;
  logic signed [DATA_W-1:0] s2_g;

  logic                     s3_valid;
  logic [ADDR_W-1:0]        s3_addr;
  logic signed [DATA_W-1:0] s3_w;
  logic signed [DATA_W-1:0] s3_g;
  logic                     s3_fwd_hit;
  logic signed [DATA_W-1:0] s3_fwd_val;
  logic signed [DATA_W-1:0] vel_q;
  logic signed [DATA_W-1:0] s3_vel;
  logic signed [PROD_W-1:0] prod_mom;
  logic signed [PROD_W-1:0] prod_grad;

  logic                     s4_valid;
  logic [ADDR_W-1:0]        s4_addr;
  logic signed [DATA_W-1:0] s4_w;
  logic signed [PROD_W-1:0] s4_pm;
  logic signed [PROD_W-1:0] s4_pg;
  logic signed [ACC_W-1:0]  acc;
  logic [ACC_W-FRAC_W-DATA_W:0] acc_top;
  logic signed [DATA_W-1:0] nv;
  logic                     nv_sat;

  logic                     s5_valid;
  logic signed [DATA_W-1:0] s5_w;
  logic signed [DATA_W-1:0] s5_nv;
  logic                     s5_sat;
  logic signed [DATA_W:0]   wsum;
  result_t                  res;
  result_t                  out_res;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_rate       <= STEP_RATE_RESET;
      momentum_factor <= MOMENTUM_FACTOR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_STEP_RATE:       step_rate       <= cfg_data;
        REG_MOMENTUM_FACTOR: momentum_factor <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // input unpacking and index reduction
  assign in_index    = s_tdata[IDX_W-1:0];
  assign in_weight   = s_tdata[IDX_W+DATA_W-1:IDX_W];
  assign in_gradient = s_tdata[IDX_W+2*DATA_W-1:IDX_W+DATA_W];

  msu_index_mod #(
    .DEPTH (ELEMENT_DEPTH)
  ) u_mod (
    .idx_in  (in_index),
    .idx_out (idx_rem)
  );

  // same entry in read and compute stages: hold the front end and insert a bubble
  assign front_stall = s2_valid && s3_valid && (s2_addr == s3_addr);
  assign s_tready    = !ram_busy && !front_stall && (occ < OCC_W'(FIFO_DEPTH));
  assign s_fire      = s_tvalid && s_tready;
  assign m_fire      = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      occ <= occ + OCC_W'(s_fire) - OCC_W'(m_fire);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
    end else begin
      if (!front_stall) begin
        s1_valid <= s_fire;
        s2_valid <= s1_valid;
      end
      s3_valid <= s2_valid && !front_stall;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!front_stall) begin
      s1_rem  <= idx_rem;
      s1_w    <= in_weight;
      s1_g    <= in_gradient;
      s2_addr <= ADDR_W'(s1_rem);
      s2_w    <= s1_w;
      s2_g    <= s1_g;
    end
    s3_addr    <= s2_addr;
    s3_w       <= s2_w;
    s3_g       <= s2_g;
    s3_fwd_hit <= s4_valid && (s4_addr == s2_addr);
    s3_fwd_val <= nv;
    s4_addr    <= s3_addr;
    s4_w       <= s3_w;
    s4_pm      <= prod_mom;
    s4_pg      <= prod_grad;
    s5_w       <= s4_w;
    s5_nv      <= nv;
    s5_sat     <= nv_sat;
  end

  msu_vel_ram #(
    .DEPTH  (ELEMENT_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_vel_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (s2_addr),
    .rd_data (vel_q),
    .wr_en   (s4_valid),
    .wr_addr (s4_addr),
    .wr_data (nv),
    .busy    (ram_busy)
  );

  // products, exact in Q16.32
  assign s3_vel    = s3_fwd_hit ? s3_fwd_val : vel_q;
  assign prod_mom  = s3_vel * $signed({1'b0, momentum_factor});
  assign prod_grad = s3_g * $signed({1'b0, step_rate});

  // difference, floor to Q16.16, clip
  assign acc     = {s4_pm[PROD_W-1], s4_pm} - {s4_pg[PROD_W-1], s4_pg};
  assign acc_top = acc[ACC_W-1:FRAC_W+DATA_W-1];

  always_comb begin
    if ((&acc_top) || !(|acc_top)) begin
      nv     = acc[FRAC_W+DATA_W-1:FRAC_W];
      nv_sat = 1'b0;
    end else begin
      nv     = acc[ACC_W-1] ? DATA_MIN : DATA_MAX;
      nv_sat = 1'b1;
    end
  end

  // weight sum and clip
  assign wsum = {s5_w[DATA_W-1], s5_w} + {s5_nv[DATA_W-1], s5_nv};

  always_comb begin
    res.velocity = s5_nv;
    if (wsum[DATA_W] != wsum[DATA_W-1]) begin
      res.weight    = wsum[DATA_W] ? DATA_MIN : DATA_MAX;
      res.saturated = 1'b1;
    end else begin
      res.weight    = wsum[DATA_W-1:0];
      res.saturated = s5_sat;
    end
  end

  msu_result_fifo u_result_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s5_valid),
    .push_data (res),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_res)
  );

  assign m_tdata = {out_res.velocity, out_res.weight};
  assign m_tuser = out_res.saturated;

  a_no_adjacent_same_entry: assert property (@(posedge clk) disable iff (rst)
    (s3_valid && s4_valid) |-> (s3_addr != s4_addr))
    else $error("read-modify-write overlap on one velocity entry");

  a_stall_inserts_bubble: assert property (@(posedge clk) disable iff (rst)
    front_stall |=> !s3_valid)
    else $error("item entered compute stage during interlock");

  a_occupancy_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= OCC_W'(FIFO_DEPTH))
    else $error("outstanding items exceed result queue depth");

  a_idle_while_clearing: assert property (@(posedge clk) disable iff (rst)
    ram_busy |-> (occ == '0 && !m_tvalid))
    else $error("item in flight during velocity clear sweep");

endmodule

// ===== tb/testbench.sv =====
module testbench;
  import msu_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = CFG_INDEX_W'(8'hc3);
  localparam int PHASE_COUNT = 6;
  localparam int ITEMS_PER_PHASE = 125;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t                kind;
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] weight;
    logic signed [DATA_W-1:0] gradient;
    logic [CFG_INDEX_W-1:0]   reg_index;
    logic [COEF_W-1:0]        reg_value;
    bit                       typed;
    result_t                  golden;
  } stim_row_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [S_TDATA_W-1:0]    s_tdata = '0;
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [M_TDATA_W-1:0]    m_tdata;
  logic                    m_tuser;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_INDEX_W-1:0]  cfg_index = '0;
  logic [COEF_W-1:0]       cfg_data = '0;

  logic [COEF_W-1:0]        rate_q16;
  logic [COEF_W-1:0]        decay_q16;
  logic signed [DATA_W-1:0] velocity_mirror [ELEMENT_DEPTH_DEFAULT];

  result_t   pending_updates [$];
  stim_row_t stim_table [$];
  int        mismatch_count = 0;
  int        gap_pct = 0;
  int        stall_pct = 0;

  momentum_sgd_update_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  function automatic longint clip_s32(input longint x, inout logic sat);
    if (x > longint'(DATA_MAX)) begin
      sat = 1'b1;
      return longint'(DATA_MAX);
    end
    if (x < longint'(DATA_MIN)) begin
      sat = 1'b1;
      return longint'(DATA_MIN);
    end
    return x;
  endfunction

  // velocity update and weight step, floor then saturate
  function automatic result_t apply_momentum_step(input logic [IDX_W-1:0] idx,
                                                  input logic signed [DATA_W-1:0] w,
                                                  input logic signed [DATA_W-1:0] g);
    longint  acc;
    longint  nv;
    longint  nw;
    logic    sat;
    result_t r;
    sat = 1'b0;
    acc = longint'(velocity_mirror[idx]) * longint'(decay_q16)
        - longint'(g) * longint'(rate_q16);
    nv = clip_s32(acc >>> FRAC_W, sat);
    nw = clip_s32(longint'(w) + nv, sat);
    velocity_mirror[idx] = DATA_W'(nv);
    r.weight = DATA_W'(nw);
    r.velocity = DATA_W'(nv);
    r.saturated = sat;
    return r;
  endfunction

  function automatic void add_item(input logic [IDX_W-1:0] idx,
                                   input logic signed [DATA_W-1:0] w,
                                   input logic signed [DATA_W-1:0] g,
                                   input bit typed = 1'b0,
                                   input logic signed [DATA_W-1:0] ew = '0,
                                   input logic signed [DATA_W-1:0] ev = '0,
                                   input logic es = 1'b0);
    stim_row_t row;
    row.kind = ROW_ITEM;
    row.idx = idx;
    row.weight = w;
    row.gradient = g;
    row.reg_index = '0;
    row.reg_value = '0;
    row.typed = typed;
    row.golden.weight = ew;
    row.golden.velocity = ev;
    row.golden.saturated = es;
    stim_table = {stim_table, row};
  endfunction

  function automatic void add_cfg(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [COEF_W-1:0] value);
    stim_row_t row;
    row.kind = ROW_CFG;
    row.idx = '0;
    row.weight = '0;
    row.gradient = '0;
    row.reg_index = index;
    row.reg_value = value;
    row.typed = 1'b0;
    row.golden = '0;
    stim_table = {stim_table, row};
  endfunction

  function automatic logic [IDX_W-1:0] pick_index(input logic [IDX_W-1:0] last);
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return last;
    if (r < 70) return IDX_W'($urandom_range(0, 7));
    return IDX_W'($urandom);
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return DATA_W'($urandom_range(0, 262143)) - DATA_W'(131072);
    if (r < 85) return DATA_W'($urandom);
    case ($urandom_range(0, 4))
      0: return DATA_MAX;
      1: return DATA_MIN;
      2: return '0;
      3: return DATA_W'(1);
      default: return '1;
    endcase
  endfunction

  task automatic drive_item(input logic [IDX_W-1:0] idx,
                            input logic signed [DATA_W-1:0] w,
                            input logic signed [DATA_W-1:0] g,
                            input bit typed,
                            input result_t golden);
    result_t r;
    while ($urandom_range(0, 99) < gap_pct) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= S_TDATA_W'({g, w, idx});
    do @(posedge clk); while (!s_tready);
    r = apply_momentum_step(idx, w, g);
    pending_updates = {pending_updates, typed ? golden : r};
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_updates.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                input logic [COEF_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (index == REG_STEP_RATE) rate_q16 = value;
    else if (index == REG_MOMENTUM_FACTOR) decay_q16 = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    forever begin
      @(negedge clk);
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_updates.size() == 0) begin
        $display("%0t: result with nothing pending, weight %h velocity %h sat %b",
                 $time, m_tdata[31:0], m_tdata[63:32], m_tuser);
        mismatch_count++;
      end else begin
        want = pending_updates.pop_front();
        if (m_tdata[31:0] !== want.weight) begin
          $display("%0t: weight expected %h actual %h", $time, want.weight, m_tdata[31:0]);
          mismatch_count++;
        end
        if (m_tdata[63:32] !== want.velocity) begin
          $display("%0t: velocity expected %h actual %h", $time, want.velocity,
                   m_tdata[63:32]);
          mismatch_count++;
        end
        if (m_tuser !== want.saturated) begin
          $display("%0t: saturated expected %b actual %b", $time, want.saturated, m_tuser);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    logic [IDX_W-1:0] last_idx;
    logic [IDX_W-1:0] idx;
    result_t          none;
    none = '0;
    last_idx = '0;
    rate_q16 = STEP_RATE_RESET;
    decay_q16 = MOMENTUM_FACTOR_RESET;
    foreach (velocity_mirror[i]) velocity_mirror[i] = '0;

    // defaults after reset, fresh entries read as zero
    add_item(IDX_W'(0), 32'h1234_5678, 0, 1'b1, 32'h1234_5678, 0, 1'b0);
    add_item(IDX_W'(4095), DATA_MAX, DATA_MIN, 1'b1, DATA_MAX, 21463040, 1'b1);
    add_item(IDX_W'(1), DATA_MIN, DATA_MAX, 1'b1, DATA_MIN, -21463040, 1'b1);
    add_item(IDX_W'(4095), 0, 0);
    add_item(IDX_W'(4095), 0, 0);
    add_item(IDX_W'(2), '1, '1);
    add_item(IDX_W'(3), 1, 1);
    // zero rate, velocity only decays
    add_cfg(REG_STEP_RATE, COEF_W'(0));
    add_item(IDX_W'(4095), 0, DATA_MAX);
    add_item(IDX_W'(1), 32'h0001_0000, DATA_MIN);
    add_cfg(REG_MOMENTUM_FACTOR, COEF_W'(0));
    add_item(IDX_W'(4095), 5, DATA_MIN, 1'b1, 5, 0, 1'b0);
    // full rate and decay drive the velocity into the rails
    add_cfg(REG_STEP_RATE, 16'hffff);
    add_cfg(REG_MOMENTUM_FACTOR, 16'hffff);
    add_item(IDX_W'(10), 0, DATA_MIN);
    add_item(IDX_W'(10), 0, DATA_MIN);
    add_item(IDX_W'(10), DATA_MIN, DATA_MIN);
    add_item(IDX_W'(11), DATA_MAX, DATA_MAX);
    add_item(IDX_W'(11), DATA_MAX, DATA_MAX);
    // unmapped register index leaves both rates alone
    add_cfg(REG_UNMAPPED, 16'h1234);
    add_item(IDX_W'(11), 0, 32'h0001_0000);
    add_item(IDX_W'(12), 32'h8000_0001, 32'h7fff_ffff);
    add_cfg(REG_STEP_RATE, STEP_RATE_RESET);
    add_cfg(REG_MOMENTUM_FACTOR, MOMENTUM_FACTOR_RESET);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (stim_table[i]) begin
      if (stim_table[i].kind == ROW_CFG) begin
        wait_for_drain();
        write_register(stim_table[i].reg_index, stim_table[i].reg_value);
      end else begin
        drive_item(stim_table[i].idx, stim_table[i].weight, stim_table[i].gradient,
                   stim_table[i].typed, stim_table[i].golden);
      end
    end

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      wait_for_drain();
      case (phase % 4)
        0: begin gap_pct = 0; stall_pct = 0; end
        1: begin gap_pct = 72; stall_pct = 0; end
        2: begin gap_pct = 0; stall_pct = 72; end
        default: begin gap_pct = 33; stall_pct = 33; end
      endcase
      case (phase)
        0: begin
          write_register(REG_STEP_RATE, STEP_RATE_RESET);
          write_register(REG_MOMENTUM_FACTOR, MOMENTUM_FACTOR_RESET);
        end
        1: begin
          write_register(REG_STEP_RATE, COEF_W'(1));
          write_register(REG_MOMENTUM_FACTOR, 16'hffff);
        end
        2: begin
          write_register(REG_STEP_RATE, 16'hffff);
          write_register(REG_MOMENTUM_FACTOR, COEF_W'(0));
        end
        3: begin
          write_register(REG_STEP_RATE, COEF_W'(0));
          write_register(REG_MOMENTUM_FACTOR, COEF_W'($urandom));
        end
        default: begin
          write_register(REG_STEP_RATE, COEF_W'($urandom));
          write_register(REG_MOMENTUM_FACTOR, COEF_W'($urandom));
          write_register(REG_UNMAPPED, COEF_W'($urandom));
        end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        idx = pick_index(last_idx);
        last_idx = idx;
        drive_item(idx, pick_value(), pick_value(), 1'b0, none);
      end
    end

    wait_for_drain();
    if (mismatch_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ===== momentum_sgd_update_core.f =====
rtl/msu_pkg.sv
rtl/msu_index_mod.sv
rtl/msu_vel_ram.sv
rtl/msu_result_fifo.sv
rtl/momentum_sgd_update_core.sv
tb/testbench.sv
